### sv/projective_pixel_address_map_top_macros.svh
// Assertion macros shared by the projective pixel address map modules.
`ifndef PROJECTIVE_PIXEL_ADDRESS_MAP_TOP_MACROS_SVH
`define PROJECTIVE_PIXEL_ADDRESS_MAP_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PPAM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PPAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### sv/ppam_pkg.sv
// Package with types, widths and constants for the projective pixel address map.
package ppam_pkg;
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 32;
    localparam int COEF_BITS  = 48;
    localparam int IDX_BITS   = 3;
    localparam int NUM_COEF   = 8;
    // Product and sum widths: coef * coord, plus two guard bits for the 3-term sum.
    localparam int PROD_BITS  = COEF_BITS + COORD_BITS + 1;
    localparam int SUM_BITS   = PROD_BITS + 2;
    localparam int MAG_BITS   = SUM_BITS;
    localparam int Q_BITS     = 16;
    localparam int REM_BITS   = MAG_BITS + 1;

    localparam logic [IDX_BITS-1:0] IDX_XX = 3'd0;
    localparam logic [IDX_BITS-1:0] IDX_XY = 3'd1;
    localparam logic [IDX_BITS-1:0] IDX_XC = 3'd2;
    localparam logic [IDX_BITS-1:0] IDX_YX = 3'd3;
    localparam logic [IDX_BITS-1:0] IDX_YY = 3'd4;
    localparam logic [IDX_BITS-1:0] IDX_YC = 3'd5;
    localparam logic [IDX_BITS-1:0] IDX_WX = 3'd6;
    localparam logic [IDX_BITS-1:0] IDX_WY = 3'd7;

    localparam logic signed [COEF_BITS-1:0] COEF_ONE =
        COEF_BITS'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic [11:0] out_col;
        logic [11:0] out_row;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] src_col;
        logic signed [15:0] src_row;
        logic               map_fault;
    } t_out_word;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] xx, xy, xc, yx, yy, yc, wx, wy;
    } t_coef_set;

    // Sign of one quotient job, plus special-case flags.
    typedef struct packed {
        logic neg;
        logic num_neg;
        logic num_zero;
        logic den_zero;
        logic ovf;
    } t_div_ctl;
endpackage

### sv/ppam_mac.sv
// Three-stage product and sum of the two numerators and the denominator.
module ppam_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  ppam_pkg::t_in_word                i_word,
    input  ppam_pkg::t_coef_set               i_coef,
    output logic                              o_valid,
    output logic signed [ppam_pkg::SUM_BITS-1:0] o_nx,
    output logic signed [ppam_pkg::SUM_BITS-1:0] o_ny,
    output logic signed [ppam_pkg::SUM_BITS-1:0] o_dw
);
    import ppam_pkg::*;

    logic                        r_v0, r_v1, r_v2;
    logic signed [COORD_BITS:0]  r_x, r_y;
    logic signed [PROD_BITS-1:0] r_pxx, r_pxy, r_pyx, r_pyy, r_pwx, r_pwy;
    logic signed [PROD_BITS-1:0] r_cx, r_cy;
    logic signed [SUM_BITS-1:0]  r_nx, r_ny, r_dw;

    // Advance valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    // Register coordinates, then multiply, then sum.
    always_ff @(posedge i_clk) begin
        r_x   <= $signed({1'b0, i_word.out_col[COORD_BITS-1:0]});
        r_y   <= $signed({1'b0, i_word.out_row[COORD_BITS-1:0]});
        r_pxx <= PROD_BITS'(i_coef.xx) * PROD_BITS'(r_x);
        r_pxy <= PROD_BITS'(i_coef.xy) * PROD_BITS'(r_y);
        r_pyx <= PROD_BITS'(i_coef.yx) * PROD_BITS'(r_x);
        r_pyy <= PROD_BITS'(i_coef.yy) * PROD_BITS'(r_y);
        r_pwx <= PROD_BITS'(i_coef.wx) * PROD_BITS'(r_x);
        r_pwy <= PROD_BITS'(i_coef.wy) * PROD_BITS'(r_y);
        r_cx  <= PROD_BITS'(i_coef.xc);
        r_cy  <= PROD_BITS'(i_coef.yc);
        r_nx  <= SUM_BITS'(r_pxx) + SUM_BITS'(r_pxy) + SUM_BITS'(r_cx);
        r_ny  <= SUM_BITS'(r_pyx) + SUM_BITS'(r_pyy) + SUM_BITS'(r_cy);
        r_dw  <= SUM_BITS'(r_pwx) + SUM_BITS'(r_pwy) + SUM_BITS'(COEF_ONE);
    end

    assign o_valid = r_v2;
    assign o_nx    = r_nx;
    assign o_ny    = r_ny;
    assign o_dw    = r_dw;
endmodule

### sv/ppam_div.sv
// Pipelined restoring divider: one quotient bit per stage, with saturation.
module ppam_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [ppam_pkg::SUM_BITS-1:0] i_num,
    input  logic signed [ppam_pkg::SUM_BITS-1:0] i_den,
    output logic                                o_valid,
    output logic signed [15:0]                  o_quo,
    output logic                                o_fault
);
    import ppam_pkg::*;
    `include "projective_pixel_address_map_top_macros.svh"

    localparam int NST = Q_BITS;

    logic                r_v0;
    logic [MAG_BITS-1:0] r_nm0, r_dm0;
    t_div_ctl            r_c0;

    logic [NST:0]                 r_v;
    logic [REM_BITS-1:0]          r_rem [NST+1];
    logic [MAG_BITS-1:0]          r_dm  [NST+1];
    logic [Q_BITS-1:0]            r_q   [NST+1];
    t_div_ctl                     r_c   [NST+1];

    logic                r_vo;
    logic signed [15:0]  r_quo;
    logic                r_flt;

    logic [MAG_BITS-1:0] n_nm, n_dm;
    logic                n_ovf;

    // Take magnitudes.
    always_comb begin
        n_nm  = i_num[SUM_BITS-1] ? MAG_BITS'(-i_num) : MAG_BITS'(i_num);
        n_dm  = i_den[SUM_BITS-1] ? MAG_BITS'(-i_den) : MAG_BITS'(i_den);
        n_ovf = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        r_nm0 <= n_nm;
        r_dm0 <= n_dm;
        r_c0  <= '{neg:      i_num[SUM_BITS-1] ^ i_den[SUM_BITS-1],
                   num_neg:  i_num[SUM_BITS-1],
                   num_zero: (i_num == '0),
                   den_zero: (i_den == '0),
                   ovf:      n_ovf};
    end

    // Overflow test: numerator >= den << 16, then seed the bit stages.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= REM_BITS'(r_nm0);
        r_dm[0]  <= r_dm0;
        r_q[0]   <= '0;
        r_c[0]   <= '{neg:      r_c0.neg,
                      num_neg:  r_c0.num_neg,
                      num_zero: r_c0.num_zero,
                      den_zero: r_c0.den_zero,
                      ovf:      ({16'd0, r_nm0} >= {r_dm0, 16'd0})};
    end

    // One quotient bit per stage, MSB first.
    for (genvar g = 0; g < NST; g++) begin : g_bit
        localparam int SH = NST - 1 - g;
        logic [REM_BITS+Q_BITS-1:0] w_t;
        assign w_t = {{(Q_BITS+1){1'b0}}, r_dm[g]} << SH;
        always_ff @(posedge i_clk) begin
            r_dm[g+1] <= r_dm[g];
            r_c[g+1]  <= r_c[g];
            if ({{Q_BITS{1'b0}}, r_rem[g]} >= w_t) begin
                r_rem[g+1] <= REM_BITS'({{Q_BITS{1'b0}}, r_rem[g]} - w_t);
                r_q[g+1]   <= r_q[g] | (Q_BITS'(1) << SH);
            end else begin
                r_rem[g+1] <= r_rem[g];
                r_q[g+1]   <= r_q[g];
            end
        end
    end

    // Advance valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v  <= '0;
            r_vo <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v  <= {r_v[NST-1:0], r_v0};
            r_vo <= r_v[NST];
        end
    end

    // Apply sign and saturate.
    always_ff @(posedge i_clk) begin
        if (r_c[NST].den_zero) begin
            r_flt <= 1'b1;
            r_quo <= r_c[NST].num_zero ? 16'sd0 :
                     (r_c[NST].num_neg ? -16'sd32768 : 16'sd32767);
        end else if (r_c[NST].ovf) begin
            r_flt <= 1'b1;
            r_quo <= r_c[NST].neg ? -16'sd32768 : 16'sd32767;
        end else if (r_c[NST].neg) begin
            r_flt <= (r_q[NST] > 16'h8000);
            r_quo <= (r_q[NST] > 16'h8000) ? -16'sd32768 : $signed(16'(-r_q[NST]));
        end else begin
            r_flt <= (r_q[NST] > 16'h7FFF);
            r_quo <= (r_q[NST] > 16'h7FFF) ? 16'sd32767 : $signed(r_q[NST]);
        end
    end

    assign o_valid = r_vo;
    assign o_quo   = r_quo;
    assign o_fault = r_flt;

    `PPAM_ASSERT_NEXT(a_div_pass, i_clk, i_rst_n, r_v[NST], o_valid)
    `PPAM_ASSERT_IMP(a_div_zero, i_clk, i_rst_n, o_valid && $past(r_c[NST].den_zero), o_fault)
    `PPAM_ASSERT_IMP(a_div_rem, i_clk, i_rst_n, r_v[NST] && !r_c[NST].ovf && !r_c[NST].den_zero,
        r_rem[NST] < REM_BITS'(r_dm[NST]))
endmodule

### sv/projective_pixel_address_map_top.sv
// Top level of the projective pixel address map: registers, multiply-add, two dividers.
//
// Usage: drive start high with a word on i_in; the block is never busy, so busy
// stays low and a new pixel is taken every clock. Coefficients are written on
// the configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_index,
// i_cfg_data); write them only while no pixel is in flight. Writes to an index
// beyond the eight registers are ignored.
// The path has 23 register stages (3 multiply-add, 19 divider: magnitude,
// overflow test, 16 quotient bits, sign and saturate; 1 output register), the
// first of them loaded by the accepting edge. Throughput: one pixel per cycle,
// set by the bit-per-stage divider pipeline.
// Each result is shown on o_out for one cycle with o_done high; the receiver
// cannot stall. Reset (i_rst_n low, synchronous) empties the pipeline and
// loads the identity transform.
module projective_pixel_address_map_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  ppam_pkg::t_in_word                 i_in,
    output logic                               o_done,
    output ppam_pkg::t_out_word                o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ppam_pkg::IDX_BITS-1:0]      i_cfg_index,
    input  logic [ppam_pkg::COEF_BITS-1:0]     i_cfg_data
);
    import ppam_pkg::*;
    `include "projective_pixel_address_map_top_macros.svh"

    t_coef_set r_coef;
    logic      w_mv;
    logic signed [SUM_BITS-1:0] w_nx, w_ny, w_dw;
    logic      w_vx, w_vy, w_fx, w_fy;
    logic signed [15:0] w_qx, w_qy;
    logic      r_done;
    t_out_word r_out;

    // Write coefficients.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '{xx: COEF_ONE, yy: COEF_ONE, default: '0};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                IDX_XX:  r_coef.xx <= i_cfg_data;
                IDX_XY:  r_coef.xy <= i_cfg_data;
                IDX_XC:  r_coef.xc <= i_cfg_data;
                IDX_YX:  r_coef.yx <= i_cfg_data;
                IDX_YY:  r_coef.yy <= i_cfg_data;
                IDX_YC:  r_coef.yc <= i_cfg_data;
                IDX_WX:  r_coef.wx <= i_cfg_data;
                IDX_WY:  r_coef.wy <= i_cfg_data;
                default: r_coef    <= r_coef;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    ppam_mac u_mac (
        .i_clk, .i_rst_n, .i_valid(start), .i_word(i_in), .i_coef(r_coef),
        .o_valid(w_mv), .o_nx(w_nx), .o_ny(w_ny), .o_dw(w_dw)
    );

    ppam_div u_div_x (
        .i_clk, .i_rst_n, .i_valid(w_mv), .i_num(w_nx), .i_den(w_dw),
        .o_valid(w_vx), .o_quo(w_qx), .o_fault(w_fx)
    );

    ppam_div u_div_y (
        .i_clk, .i_rst_n, .i_valid(w_mv), .i_num(w_ny), .i_den(w_dw),
        .o_valid(w_vy), .o_quo(w_qy), .o_fault(w_fy)
    );

    // Register the result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_vx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= '{src_col: w_qx, src_row: w_qy, map_fault: w_fx | w_fy};
    end

    assign o_done = r_done;
    assign o_out  = r_out;

    `PPAM_ASSERT_IMP(a_lanes_aligned, i_clk, i_rst_n, 1'b1, w_vx == w_vy)
    `PPAM_ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, w_vx, o_done)
    `PPAM_ASSERT_NEXT(a_fault_or, i_clk, i_rst_n, w_vx, o_out.map_fault == $past(w_fx | w_fy))
endmodule

### dv/projective_pixel_address_map_checker.sv
// Checker for the projective pixel address map: predicts each source coordinate and compares.
`timescale 1ns / 100ps
module projective_pixel_address_map_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  ppam_pkg::t_in_word                  i_in,
    input  logic                                i_done,
    input  ppam_pkg::t_out_word                 i_out,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [ppam_pkg::IDX_BITS-1:0]       i_cfg_index,
    input  logic [ppam_pkg::COEF_BITS-1:0]      i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import ppam_pkg::*;

    logic signed [COEF_BITS-1:0] coef [NUM_COEF];
    t_out_word mapped_q [$];

    // Divide one numerator by the common denominator, truncate and saturate.
    function automatic logic [15:0] src_quotient(input logic signed [127:0] num,
                                                 input logic signed [127:0] den,
                                                 inout logic fault);
        logic signed [127:0] q;
        if (den == 0) begin
            fault = 1'b1;
            if (num == 0) return 16'h0000;
            return (num < 0) ? 16'h8000 : 16'h7FFF;
        end
        q = num / den;
        if (q > 32767) begin
            fault = 1'b1;
            return 16'h7FFF;
        end
        if (q < -32768) begin
            fault = 1'b1;
            return 16'h8000;
        end
        return q[15:0];
    endfunction

    function automatic t_out_word map_pixel(input t_in_word w);
        logic signed [127:0] x, y, nx, ny, dw;
        logic fault;
        t_out_word r;
        x = {116'd0, w.out_col};
        y = {116'd0, w.out_row};
        fault = 1'b0;
        nx = coef[IDX_XX] * x + coef[IDX_XY] * y + coef[IDX_XC];
        ny = coef[IDX_YX] * x + coef[IDX_YY] * y + coef[IDX_YC];
        dw = coef[IDX_WX] * x + coef[IDX_WY] * y + (128'sd1 <<< FRAC_BITS);
        r.src_col = src_quotient(nx, dw, fault);
        r.src_row = src_quotient(ny, dw, fault);
        r.map_fault = fault;
        return r;
    endfunction

    assign o_pending = mapped_q.size();

    // Track coefficient writes, predict accepted words, check results.
    always @(posedge i_clk) begin
        t_out_word e;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF; i++)
                coef[i] <= (IDX_BITS'(i) == IDX_XX || IDX_BITS'(i) == IDX_YY) ? COEF_ONE : '0;
            mapped_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) coef[i_cfg_index] <= i_cfg_data;
            if (i_start && !i_busy) mapped_q.push_back(map_pixel(i_in));
            if (i_done) begin
                if (mapped_q.size() == 0) begin
                    $error("result word with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = mapped_q.pop_front();
                    if (e.src_col !== i_out.src_col)
                        $error("src_col expected %0d actual %0d", e.src_col, i_out.src_col);
                    if (e.src_row !== i_out.src_row)
                        $error("src_row expected %0d actual %0d", e.src_row, i_out.src_row);
                    if (e.map_fault !== i_out.map_fault)
                        $error("map_fault expected %0d actual %0d",
                               e.map_fault, i_out.map_fault);
                    if (e !== i_out) o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end
endmodule

### dv/projective_pixel_address_map_top_test.sv
// Testbench top for the projective pixel address map: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module projective_pixel_address_map_top_test;
    import ppam_pkg::*;

    localparam int LATENCY = 22;

    logic i_clk, i_rst_n, start, busy, o_done, i_cfg_valid, o_cfg_ready;
    t_in_word i_in;
    t_out_word o_out;
    logic [IDX_BITS-1:0] i_cfg_index;
    logic [COEF_BITS-1:0] i_cfg_data;
    int fail_count, pending;
    int idle_pct;

    projective_pixel_address_map_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_in(i_in),
        .o_done(o_done), .o_out(o_out), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    projective_pixel_address_map_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_in(i_in),
        .i_done(o_done), .i_out(o_out), .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

    // Send one pixel word, idling first at the current rate.
    task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_in <= '{out_col: col, out_row: row};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Wait for the pipeline to empty.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Write one register, then drop valid.
    task automatic write_coef(input logic [IDX_BITS-1:0] idx, input logic [47:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand_coef(input int kind);
        logic [47:0] v;
        v = 48'({$urandom, $urandom});
        case (kind)
            0: return 48'h7FFF_FFFF_FFFF;
            1: return 48'h8000_0000_0000;
            2: return 48'd0;
            3: return v;
            4: return {{20{v[27]}}, v[27:0]};
            default: return {{12{v[35]}}, v[35:0]};
        endcase
    endfunction

    // Pick a coefficient set: all maximum, all minimum, identity, or random mixed-size values.
    task automatic load_setting(input int kind);
        for (int i = 0; i < NUM_COEF; i++) begin
            case (kind)
                0: write_coef(IDX_BITS'(i), 48'h7FFF_FFFF_FFFF);
                1: write_coef(IDX_BITS'(i), 48'h8000_0000_0000);
                2: write_coef(IDX_BITS'(i),
                              (IDX_BITS'(i) == IDX_XX || IDX_BITS'(i) == IDX_YY) ?
                              COEF_ONE : 48'd0);
                default: begin
                    if (IDX_BITS'(i) >= IDX_WX)
                        write_coef(IDX_BITS'(i), rand_coef($urandom_range(2, 4)));
                    else write_coef(IDX_BITS'(i), rand_coef($urandom_range(2, 5)));
                end
            endcase
        end
    endtask

    initial begin
        logic [11:0] col, row;
        int kind;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        idle_pct = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity at reset, field extremes.
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'hFFF, 12'd0);
        send_pixel(12'd0, 12'hFFF);
        send_pixel(12'hAAA, 12'h555);
        drain();
        // Zero denominator at x=1: wx = -1.0, numerators positive, negative, zero.
        write_coef(IDX_WX, -COEF_ONE);
        write_coef(IDX_XC, COEF_ONE);
        write_coef(IDX_YY, -COEF_ONE);
        write_coef(IDX_XX, 48'd0);
        send_pixel(12'd1, 12'd5);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd2, 12'd3);
        drain();
        // Quotient overflow at +32768, just below it, and negative quotients down to -32760.
        write_coef(IDX_WX, 48'd0);
        write_coef(IDX_XC, 48'd0);
        write_coef(IDX_XX, COEF_ONE <<< 4);
        write_coef(IDX_YY, -(COEF_ONE <<< 3));
        send_pixel(12'd2048, 12'd4095);
        send_pixel(12'd2047, 12'd4095);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd0, 12'd1);
        drain();
        load_setting(0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd3, 12'd7);
        drain();
        load_setting(1);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd9, 12'd1);
        drain();

        // Random phases over several settings and idling rates.
        for (int ph = 0; ph < 24; ph++) begin
            kind = (ph % 6 == 5) ? $urandom_range(0, 2) : 3;
            load_setting(kind);
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 50;
                2: idle_pct = 34;
                default: idle_pct = $urandom_range(0, 70);
            endcase
            for (int n = 0; n < 80; n++) begin
                col = 12'($urandom);
                row = 12'($urandom);
                if ($urandom_range(3) == 0) begin
                    col = 12'($urandom_range(0, 15));
                    row = 12'($urandom_range(0, 15));
                end
                send_pixel(col, row);
            end
            drain();
        end
        load_setting(2);

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
